/* src/rdu_pkg.sv */
// Shared types, constants and the sequencer microcode for the lens distortion core.
// Used by rdu_alu and radtan_distort_undistort_core; no dependencies.
package rdu_pkg;

    localparam int WORD_W          = 64;
    localparam int PROD_W          = 128;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;
    localparam int SLOT_COUNT      = 32;
    localparam int SLOT_W          = 5;
    localparam int SRC_W           = 6;
    localparam int PC_W            = 7;
    localparam int CFG_IDX_W       = 3;
    localparam int STEPS_W         = 8;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd200;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_K1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd5;

    typedef enum logic [3:0] {
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_DIV,
        UOP_BRDIST,
        UOP_NEAR,
        UOP_END0,
        UOP_TSTZ,
        UOP_LOOP
    } uop_t;

    typedef struct packed {
        uop_t              op;
        logic [SLOT_W-1:0] dst;
        logic [SRC_W-1:0]  a;
        logic [SRC_W-1:0]  b;
    } uinst_t;

    typedef struct packed {
        logic start;
        uop_t op;
    } alu_cmd_t;

    // operand codes: below 32 a scratch slot, from 32 on a constant or register
    localparam logic [SRC_W-1:0] O_RX   = 6'd0;
    localparam logic [SRC_W-1:0] O_RY   = 6'd1;
    localparam logic [SRC_W-1:0] O_X2   = 6'd2;
    localparam logic [SRC_W-1:0] O_Y2   = 6'd3;
    localparam logic [SRC_W-1:0] O_XY   = 6'd4;
    localparam logic [SRC_W-1:0] O_R2   = 6'd5;
    localparam logic [SRC_W-1:0] O_R4   = 6'd6;
    localparam logic [SRC_W-1:0] O_R6   = 6'd7;
    localparam logic [SRC_W-1:0] O_T    = 6'd8;
    localparam logic [SRC_W-1:0] O_U    = 6'd9;
    localparam logic [SRC_W-1:0] O_RAD  = 6'd10;
    localparam logic [SRC_W-1:0] O_XD   = 6'd11;
    localparam logic [SRC_W-1:0] O_YD   = 6'd12;
    localparam logic [SRC_W-1:0] O_EX   = 6'd13;
    localparam logic [SRC_W-1:0] O_EY   = 6'd14;
    localparam logic [SRC_W-1:0] O_G    = 6'd15;
    localparam logic [SRC_W-1:0] O_BASE = 6'd16;
    localparam logic [SRC_W-1:0] O_JA   = 6'd17;
    localparam logic [SRC_W-1:0] O_JB   = 6'd18;
    localparam logic [SRC_W-1:0] O_JD   = 6'd19;
    localparam logic [SRC_W-1:0] O_A2   = 6'd20;
    localparam logic [SRC_W-1:0] O_B2   = 6'd21;
    localparam logic [SRC_W-1:0] O_V    = 6'd22;
    localparam logic [SRC_W-1:0] O_P    = 6'd23;
    localparam logic [SRC_W-1:0] O_DET  = 6'd24;
    localparam logic [SRC_W-1:0] O_N    = 6'd25;
    localparam logic [SRC_W-1:0] O_Q    = 6'd26;
    localparam logic [SRC_W-1:0] O_ZERO = 6'd32;
    localparam logic [SRC_W-1:0] O_ONE  = 6'd33;
    localparam logic [SRC_W-1:0] O_K1   = 6'd34;
    localparam logic [SRC_W-1:0] O_K2   = 6'd35;
    localparam logic [SRC_W-1:0] O_K3   = 6'd36;
    localparam logic [SRC_W-1:0] O_P1   = 6'd37;
    localparam logic [SRC_W-1:0] O_P2   = 6'd38;
    localparam logic [SRC_W-1:0] O_X    = 6'd39;
    localparam logic [SRC_W-1:0] O_Y    = 6'd40;

    localparam logic [PC_W-1:0] DIST_START = 7'd7;

    function automatic uinst_t ui(uop_t op, logic [SRC_W-1:0] d,
                                  logic [SRC_W-1:0] a, logic [SRC_W-1:0] b);
        uinst_t w;
        w.op  = op;
        w.dst = d[SLOT_W-1:0];
        w.a   = a;
        w.b   = b;
        return w;
    endfunction

    // microcode: setup, near-center test, distortion, Jacobian, Newton update
    function automatic uinst_t ucode(logic [PC_W-1:0] pc);
        uinst_t w;
        unique case (pc)
            7'd0:  w = ui(UOP_ADD, O_RX, O_X, O_ZERO);
            7'd1:  w = ui(UOP_ADD, O_RY, O_Y, O_ZERO);
            7'd2:  w = ui(UOP_BRDIST, O_ZERO, O_ZERO, O_ZERO);
            7'd3:  w = ui(UOP_MUL, O_T, O_X, O_X);
            7'd4:  w = ui(UOP_MUL, O_U, O_Y, O_Y);
            7'd5:  w = ui(UOP_ADD, O_T, O_T, O_U);
            7'd6:  w = ui(UOP_NEAR, O_ZERO, O_T, O_ZERO);
            7'd7:  w = ui(UOP_MUL, O_X2, O_RX, O_RX);
            7'd8:  w = ui(UOP_MUL, O_Y2, O_RY, O_RY);
            7'd9:  w = ui(UOP_MUL, O_XY, O_RX, O_RY);
            7'd10: w = ui(UOP_ADD, O_R2, O_X2, O_Y2);
            7'd11: w = ui(UOP_MUL, O_R4, O_R2, O_R2);
            7'd12: w = ui(UOP_MUL, O_R6, O_R4, O_R2);
            7'd13: w = ui(UOP_MUL, O_T, O_K1, O_R2);
            7'd14: w = ui(UOP_MUL, O_U, O_K2, O_R4);
            7'd15: w = ui(UOP_ADD, O_T, O_T, O_U);
            7'd16: w = ui(UOP_MUL, O_U, O_K3, O_R6);
            7'd17: w = ui(UOP_ADD, O_RAD, O_T, O_U);
            7'd18: w = ui(UOP_MUL, O_T, O_RX, O_RAD);
            7'd19: w = ui(UOP_MUL, O_U, O_P1, O_XY);
            7'd20: w = ui(UOP_ADD, O_U, O_U, O_U);
            7'd21: w = ui(UOP_ADD, O_T, O_T, O_U);
            7'd22: w = ui(UOP_ADD, O_U, O_X2, O_X2);
            7'd23: w = ui(UOP_ADD, O_U, O_R2, O_U);
            7'd24: w = ui(UOP_MUL, O_U, O_P2, O_U);
            7'd25: w = ui(UOP_ADD, O_T, O_T, O_U);
            7'd26: w = ui(UOP_ADD, O_XD, O_RX, O_T);
            7'd27: w = ui(UOP_MUL, O_T, O_RY, O_RAD);
            7'd28: w = ui(UOP_MUL, O_U, O_P2, O_XY);
            7'd29: w = ui(UOP_ADD, O_U, O_U, O_U);
            7'd30: w = ui(UOP_ADD, O_T, O_T, O_U);
            7'd31: w = ui(UOP_ADD, O_U, O_Y2, O_Y2);
            7'd32: w = ui(UOP_ADD, O_U, O_R2, O_U);
            7'd33: w = ui(UOP_MUL, O_U, O_P1, O_U);
            7'd34: w = ui(UOP_ADD, O_T, O_T, O_U);
            7'd35: w = ui(UOP_ADD, O_YD, O_RY, O_T);
            7'd36: w = ui(UOP_END0, O_ZERO, O_ZERO, O_ZERO);
            7'd37: w = ui(UOP_SUB, O_EX, O_X, O_XD);
            7'd38: w = ui(UOP_SUB, O_EY, O_Y, O_YD);
            7'd39: w = ui(UOP_ADD, O_G, O_K1, O_K1);
            7'd40: w = ui(UOP_MUL, O_T, O_K2, O_R2);
            7'd41: w = ui(UOP_ADD, O_U, O_T, O_T);
            7'd42: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd43: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd44: w = ui(UOP_ADD, O_G, O_G, O_U);
            7'd45: w = ui(UOP_MUL, O_T, O_K3, O_R4);
            7'd46: w = ui(UOP_ADD, O_U, O_T, O_T);
            7'd47: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd48: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd49: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd50: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd51: w = ui(UOP_ADD, O_G, O_G, O_U);
            7'd52: w = ui(UOP_ADD, O_BASE, O_ONE, O_RAD);
            7'd53: w = ui(UOP_MUL, O_T, O_G, O_X2);
            7'd54: w = ui(UOP_ADD, O_JA, O_BASE, O_T);
            7'd55: w = ui(UOP_MUL, O_T, O_P1, O_RY);
            7'd56: w = ui(UOP_ADD, O_B2, O_T, O_T);
            7'd57: w = ui(UOP_ADD, O_U, O_B2, O_T);
            7'd58: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd59: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd60: w = ui(UOP_ADD, O_V, O_U, O_T);
            7'd61: w = ui(UOP_ADD, O_JA, O_JA, O_B2);
            7'd62: w = ui(UOP_MUL, O_T, O_P2, O_RX);
            7'd63: w = ui(UOP_ADD, O_A2, O_T, O_T);
            7'd64: w = ui(UOP_ADD, O_U, O_A2, O_T);
            7'd65: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd66: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd67: w = ui(UOP_ADD, O_U, O_U, O_T);
            7'd68: w = ui(UOP_ADD, O_JA, O_JA, O_U);
            7'd69: w = ui(UOP_MUL, O_T, O_G, O_XY);
            7'd70: w = ui(UOP_MUL, O_P, O_P1, O_RX);
            7'd71: w = ui(UOP_ADD, O_P, O_P, O_P);
            7'd72: w = ui(UOP_ADD, O_JB, O_T, O_P);
            7'd73: w = ui(UOP_MUL, O_P, O_P2, O_RY);
            7'd74: w = ui(UOP_ADD, O_P, O_P, O_P);
            7'd75: w = ui(UOP_ADD, O_JB, O_JB, O_P);
            7'd76: w = ui(UOP_MUL, O_T, O_G, O_Y2);
            7'd77: w = ui(UOP_ADD, O_JD, O_BASE, O_T);
            7'd78: w = ui(UOP_ADD, O_JD, O_JD, O_A2);
            7'd79: w = ui(UOP_ADD, O_JD, O_JD, O_V);
            7'd80: w = ui(UOP_MUL, O_T, O_JA, O_JD);
            7'd81: w = ui(UOP_MUL, O_U, O_JB, O_JB);
            7'd82: w = ui(UOP_SUB, O_DET, O_T, O_U);
            7'd83: w = ui(UOP_TSTZ, O_ZERO, O_DET, O_ZERO);
            7'd84: w = ui(UOP_MUL, O_T, O_JD, O_EX);
            7'd85: w = ui(UOP_MUL, O_U, O_JB, O_EY);
            7'd86: w = ui(UOP_SUB, O_N, O_T, O_U);
            7'd87: w = ui(UOP_DIV, O_Q, O_N, O_DET);
            7'd88: w = ui(UOP_ADD, O_RX, O_RX, O_Q);
            7'd89: w = ui(UOP_MUL, O_T, O_JA, O_EY);
            7'd90: w = ui(UOP_MUL, O_U, O_JB, O_EX);
            7'd91: w = ui(UOP_SUB, O_N, O_T, O_U);
            7'd92: w = ui(UOP_DIV, O_Q, O_N, O_DET);
            7'd93: w = ui(UOP_ADD, O_RY, O_RY, O_Q);
            default: w = ui(UOP_LOOP, O_ZERO, O_ZERO, O_ZERO);
        endcase
        return w;
    endfunction

endpackage

/* src/rdu_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module rdu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* src/rdu_alu.sv */
// Shared saturating fixed-point unit: add, subtract, rounded multiply (four 32x32
// partial products) and restoring divide (one quotient bit a cycle). Uses rdu_pkg.
module rdu_alu #(
    parameter int FRAC_BITS = rdu_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rdu_pkg::alu_cmd_t          cmd,
    input  logic [rdu_pkg::WORD_W-1:0] op_a,
    input  logic [rdu_pkg::WORD_W-1:0] op_b,
    output logic                       done,
    output logic [rdu_pkg::WORD_W-1:0] result
);

    localparam int W  = rdu_pkg::WORD_W;
    localparam int PW = rdu_pkg::PROD_W;
    localparam int HW = W / 2;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {A_IDLE, A_MUL, A_FIX, A_RND, A_SAT, A_DIV, A_DSGN} astate_t;

    astate_t      state_reg;
    logic [6:0]   cnt_reg;
    logic [W-1:0] a_reg, b_reg, pp_reg, rem_reg, q_reg, res_reg;
    logic [PW-1:0] acc_reg;
    logic         over_reg, neg_reg, done_reg;

    function automatic logic [W-1:0] sat65(logic [W:0] s);
        if (s[W] != s[W-1]) begin
            return s[W] ? SMIN : SMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag(logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    logic [W:0]      sum_ext, diff_ext;
    logic [HW-1:0]   a_half, b_half;
    logic [W-1:0]    pp;
    logic [1:0]      prev_k;
    logic [PW-1:0]   addend;
    logic signed [PW-1:0] shifted;
    logic            fits;
    logic [W-1:0]    rem_sh, q_sat;
    logic            ge;
    logic            is_div;

    assign sum_ext  = {op_a[W-1], op_a} + {op_b[W-1], op_b};
    assign diff_ext = {op_a[W-1], op_a} - {op_b[W-1], op_b};
    assign is_div   = (cmd.op == rdu_pkg::UOP_DIV);

    assign a_half = cnt_reg[1] ? a_reg[W-1:HW] : a_reg[HW-1:0];
    assign b_half = cnt_reg[0] ? b_reg[W-1:HW] : b_reg[HW-1:0];
    assign pp     = W'(a_half) * W'(b_half);
    assign prev_k = cnt_reg[1:0] - 2'd1;

    always_comb begin
        case (prev_k)
            2'd0:    addend = {{W{1'b0}}, pp_reg};
            2'd3:    addend = {pp_reg, {W{1'b0}}};
            default: addend = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
        endcase
    end

    assign shifted = $signed(acc_reg) >>> FRAC_BITS;
    assign fits    = (&shifted[PW-1:W-1]) | ~(|shifted[PW-1:W-1]);

    assign rem_sh = {rem_reg[W-2:0], acc_reg[PW-1]};
    assign ge     = rem_sh >= b_reg;
    assign q_sat  = (over_reg | q_reg[W-1]) ? SMAX : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (cmd.start) begin
                        a_reg    <= op_a;
                        // the divider works on magnitudes, the dividend pre-shifted
                        b_reg    <= is_div ? mag(op_b) : op_b;
                        acc_reg  <= is_div ? ({{W{1'b0}}, mag(op_a)} << FRAC_BITS) : '0;
                        cnt_reg  <= '0;
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        over_reg <= 1'b0;
                        neg_reg  <= op_a[W-1] ^ op_b[W-1];
                        case (cmd.op)
                            rdu_pkg::UOP_ADD: begin
                                res_reg  <= sat65(sum_ext);
                                done_reg <= 1'b1;
                            end
                            rdu_pkg::UOP_SUB: begin
                                res_reg  <= sat65(diff_ext);
                                done_reg <= 1'b1;
                            end
                            rdu_pkg::UOP_DIV: begin
                                state_reg <= A_DIV;
                            end
                            default: state_reg <= A_MUL;
                        endcase
                    end
                end
                A_MUL: begin
                    if (cnt_reg < 7'd4) begin
                        pp_reg <= pp;
                    end
                    if (cnt_reg != 7'd0) begin
                        acc_reg <= acc_reg + addend;
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd4) begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX: begin
                    // signed correction of the unsigned product's upper half
                    acc_reg[PW-1:W] <= acc_reg[PW-1:W] - (a_reg[W-1] ? b_reg : '0)
                                                       - (b_reg[W-1] ? a_reg : '0);
                    state_reg <= A_RND;
                end
                A_RND: begin
                    acc_reg   <= acc_reg + HALF;
                    state_reg <= A_SAT;
                end
                A_SAT: begin
                    res_reg   <= fits ? shifted[W-1:0] : (acc_reg[PW-1] ? SMIN : SMAX);
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_DIV: begin
                    acc_reg  <= acc_reg << 1;
                    over_reg <= over_reg | q_reg[W-1];
                    q_reg    <= {q_reg[W-2:0], ge};
                    rem_reg  <= ge ? (rem_sh - b_reg) : rem_sh;
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127) begin
                        state_reg <= A_DSGN;
                    end
                end
                A_DSGN: begin
                    res_reg   <= neg_reg ? (~q_sat + W'(1)) : q_sat;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* src/radtan_distort_undistort_core.sv */
// Top level of the radial/tangential lens distortion core: configuration registers,
// microcoded sequencer, scratch RAM. Uses rdu_pkg, rdu_ram and rdu_alu.
//
// Usage:
//   Write k1, k2, k3, p1, p2 and the Newton step count through cfg_we/cfg_index/
//   cfg_wdata while the core is idle. Send a point on the s_ channel (s_mode 0
//   distorts, 1 undistorts); one result per request comes out on the m_ channel
//   with x, y saturated to the coordinate width and a singular-Jacobian flag.
//   Each microcode step goes fetch, operand read, execute in the shared
//   arithmetic unit and write-back. Undistort runs up to newton_steps Newton
//   steps. One request is in work at a time; s_ready is high only while the
//   sequencer is idle.
//   The result sits in an output register; the next request is taken while it
//   waits, and a finished request holds in the sequencer until the receiver
//   takes the previous result.
//   Reset clears the coefficients to zero, the step count to 200 and empties
//   the output register. The scratch RAM needs no clearing.
module radtan_distort_undistort_core #(
    parameter int COORD_WIDTH = rdu_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rdu_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rdu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic signed [COORD_WIDTH-1:0] s_x_in,
    input  logic signed [COORD_WIDTH-1:0] s_y_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_x_out,
    output logic signed [COORD_WIDTH-1:0] m_y_out,
    output logic                          m_singular
);

    localparam int W  = rdu_pkg::WORD_W;
    localparam int SW = rdu_pkg::SLOT_W;
    localparam logic [W-1:0] ONE_FX   = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] NEAR_EPS = ((W'(1) << FRAC_BITS) + W'(500000)) / W'(1000000);
    localparam logic [W-1:0] FMAX     = {1'b0, {(W-1){1'b1}}} >> (W - COORD_WIDTH);
    localparam logic [W-1:0] FMIN     = ~FMAX;

    typedef enum logic [2:0] {T_IDLE, T_FETCH, T_EXEC, T_WAIT, T_OUTRD, T_OUTCAP} tstate_t;

    tstate_t  state_reg;
    logic [rdu_pkg::PC_W-1:0]    pc_reg;
    logic [rdu_pkg::STEPS_W-1:0] cnt_reg, steps_reg;
    logic [COORD_WIDTH-1:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic [W-1:0]  x_reg, y_reg;
    logic          mode_reg, sing_reg;
    logic [SW-1:0] out_a_reg, out_b_reg;
    logic          m_valid_reg, m_sing_reg;
    logic [COORD_WIDTH-1:0] m_x_reg, m_y_reg;

    rdu_pkg::uinst_t  uinst;
    rdu_pkg::alu_cmd_t alu_cmd;
    logic [W-1:0]  rd_a, rd_b, opnd_a, opnd_b, alu_res;
    logic          alu_done, ram_we, out_ready, out_load;
    logic [SW-1:0] raddr_a, raddr_b;

    function automatic logic [W-1:0] widen(logic [COORD_WIDTH-1:0] v);
        return W'($signed(v));
    endfunction

    function automatic logic [COORD_WIDTH-1:0] narrow(logic [W-1:0] v);
        logic [W-1:0] s;
        s = v;
        if ($signed(v) > $signed(FMAX)) begin
            s = FMAX;
        end else if ($signed(v) < $signed(FMIN)) begin
            s = FMIN;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [W-1:0] src_val(logic [rdu_pkg::SRC_W-1:0] code,
                                             logic [W-1:0] rd);
        logic [W-1:0] v;
        unique case (code)
            rdu_pkg::O_ZERO: v = '0;
            rdu_pkg::O_ONE:  v = ONE_FX;
            rdu_pkg::O_K1:   v = widen(k1_reg);
            rdu_pkg::O_K2:   v = widen(k2_reg);
            rdu_pkg::O_K3:   v = widen(k3_reg);
            rdu_pkg::O_P1:   v = widen(p1_reg);
            rdu_pkg::O_P2:   v = widen(p2_reg);
            rdu_pkg::O_X:    v = x_reg;
            rdu_pkg::O_Y:    v = y_reg;
            default:         v = rd;
        endcase
        return v;
    endfunction

    assign uinst   = rdu_pkg::ucode(pc_reg);

    always_comb begin
        opnd_a = src_val(uinst.a, rd_a);
        opnd_b = src_val(uinst.b, rd_b);
    end

    assign raddr_a = (state_reg == T_OUTRD || state_reg == T_OUTCAP) ? out_a_reg
                                                                      : uinst.a[SW-1:0];
    assign raddr_b = (state_reg == T_OUTRD || state_reg == T_OUTCAP) ? out_b_reg
                                                                      : uinst.b[SW-1:0];
    assign ram_we  = (state_reg == T_WAIT) && alu_done;

    always_comb begin
        alu_cmd.op    = uinst.op;
        alu_cmd.start = (state_reg == T_EXEC) &&
                        (uinst.op == rdu_pkg::UOP_ADD || uinst.op == rdu_pkg::UOP_SUB ||
                         uinst.op == rdu_pkg::UOP_MUL || uinst.op == rdu_pkg::UOP_DIV);
    end

    rdu_ram #(
        .WIDTH (W),
        .DEPTH (rdu_pkg::SLOT_COUNT)
    ) u_scratch (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (uinst.dst),
        .wdata   (alu_res),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    rdu_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .op_a    (opnd_a),
        .op_b    (opnd_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            steps_reg <= rdu_pkg::STEPS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rdu_pkg::REG_K1:    k1_reg    <= cfg_wdata;
                rdu_pkg::REG_K2:    k2_reg    <= cfg_wdata;
                rdu_pkg::REG_K3:    k3_reg    <= cfg_wdata;
                rdu_pkg::REG_P1:    p1_reg    <= cfg_wdata;
                rdu_pkg::REG_P2:    p2_reg    <= cfg_wdata;
                rdu_pkg::REG_STEPS: steps_reg <= cfg_wdata[rdu_pkg::STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == T_OUTCAP) && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
            pc_reg      <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_mode;
                        x_reg     <= widen(s_x_in);
                        y_reg     <= widen(s_y_in);
                        cnt_reg   <= '0;
                        sing_reg  <= 1'b0;
                        pc_reg    <= '0;
                        state_reg <= T_FETCH;
                    end
                end
                T_FETCH: state_reg <= T_EXEC;
                T_EXEC: begin
                    unique case (uinst.op)
                        rdu_pkg::UOP_BRDIST: begin
                            pc_reg    <= mode_reg ? pc_reg + 7'd1 : rdu_pkg::DIST_START;
                            state_reg <= T_FETCH;
                        end
                        rdu_pkg::UOP_NEAR: begin
                            if ($signed(opnd_a) < $signed(NEAR_EPS) || steps_reg == '0) begin
                                out_a_reg <= rdu_pkg::O_RX[SW-1:0];
                                out_b_reg <= rdu_pkg::O_RY[SW-1:0];
                                state_reg <= T_OUTRD;
                            end else begin
                                pc_reg    <= pc_reg + 7'd1;
                                state_reg <= T_FETCH;
                            end
                        end
                        rdu_pkg::UOP_END0: begin
                            if (!mode_reg) begin
                                out_a_reg <= rdu_pkg::O_XD[SW-1:0];
                                out_b_reg <= rdu_pkg::O_YD[SW-1:0];
                                state_reg <= T_OUTRD;
                            end else begin
                                pc_reg    <= pc_reg + 7'd1;
                                state_reg <= T_FETCH;
                            end
                        end
                        rdu_pkg::UOP_TSTZ: begin
                            if (opnd_a == '0) begin
                                sing_reg  <= 1'b1;
                                out_a_reg <= rdu_pkg::O_RX[SW-1:0];
                                out_b_reg <= rdu_pkg::O_RY[SW-1:0];
                                state_reg <= T_OUTRD;
                            end else begin
                                pc_reg    <= pc_reg + 7'd1;
                                state_reg <= T_FETCH;
                            end
                        end
                        rdu_pkg::UOP_LOOP: begin
                            if (cnt_reg + 8'd1 == steps_reg) begin
                                out_a_reg <= rdu_pkg::O_RX[SW-1:0];
                                out_b_reg <= rdu_pkg::O_RY[SW-1:0];
                                state_reg <= T_OUTRD;
                            end else begin
                                cnt_reg   <= cnt_reg + 8'd1;
                                pc_reg    <= rdu_pkg::DIST_START;
                                state_reg <= T_FETCH;
                            end
                        end
                        default: state_reg <= T_WAIT;
                    endcase
                end
                T_WAIT: begin
                    if (alu_done) begin
                        pc_reg    <= pc_reg + 7'd1;
                        state_reg <= T_FETCH;
                    end
                end
                T_OUTRD: state_reg <= T_OUTCAP;
                T_OUTCAP: begin
                    // hold until the output register is free
                    if (out_ready) begin
                        m_x_reg     <= narrow(rd_a);
                        m_y_reg     <= narrow(rd_b);
                        m_sing_reg  <= sing_reg;
                        state_reg   <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == T_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_x_out    = m_x_reg;
    assign m_y_out    = m_y_reg;
    assign m_singular = m_sing_reg;

endmodule

/* verif/testbench.sv */
// Self-checking bench for radtan_distort_undistort_core: table-driven directed points,
// then random points and coefficients, checked against literal expected results or
// a fixed-point lens model. Depends on rdu_pkg and the core sources.
module testbench;

    typedef logic signed [63:0] fx_t;
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        sing;
    } point_res_t;
    typedef struct packed {
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [7:0]  steps;
    } coeffs_t;
    typedef struct packed {
        logic [2:0]  cset;
        logic        mode;
        logic [31:0] x;
        logic [31:0] y;
        logic        lit;
        logic [31:0] ex;
        logic [31:0] ey;
        logic        es;
    } stim_row_t;

    localparam fx_t FX_MAX = 64'sh7fffffffffffffff;
    localparam fx_t FX_MIN = 64'sh8000000000000000;
    localparam fx_t ONE_FX = 64'sd1 <<< 28;
    localparam fx_t NEAR_EPS = (64'sd268435456 + 64'sd500000) / 64'sd1000000;
    localparam logic [rdu_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [rdu_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;
    localparam logic MODE_DIST = 1'b0;
    localparam logic MODE_UNDIST = 1'b1;
    localparam int QUIET_LIMIT = 1000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [rdu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_mode = 0;
    logic signed [31:0] s_x_in = '0;
    logic signed [31:0] s_y_in = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic signed [31:0] m_x_out;
    logic signed [31:0] m_y_out;
    logic        m_singular;

    radtan_distort_undistort_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_x_in(s_x_in), .s_y_in(s_y_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_x_out(m_x_out), .m_y_out(m_y_out), .m_singular(m_singular)
    );

    always #1 aclk = ~aclk;

    // shadow of the coefficient registers
    fx_t c_k1 = 0, c_k2 = 0, c_k3 = 0, c_p1 = 0, c_p2 = 0;
    int  c_steps = 200;

    point_res_t pending_points[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  requests_sent = 0;
    bit  calm = 0;

    function automatic fx_t sat_add(fx_t a, fx_t b);
        fx_t r;
        r = a + b;
        if (!a[63] && !b[63] && r[63]) return FX_MAX;
        if (a[63] && b[63] && !r[63]) return FX_MIN;
        return r;
    endfunction

    function automatic fx_t sat_sub(fx_t a, fx_t b);
        if (b == FX_MIN) return a[63] ? sat_add(sat_add(a, FX_MAX), 1) : FX_MAX;
        return sat_add(a, -b);
    endfunction

    function automatic fx_t rep_add(fx_t v, int n);
        fx_t r;
        r = 0;
        for (int i = 0; i < n; i++) r = sat_add(r, v);
        return r;
    endfunction

    function automatic fx_t fx_mul(fx_t a, fx_t b);
        logic signed [127:0] wa, wb, p, wmax, wmin;
        wa = a;
        wb = b;
        wmax = FX_MAX;
        wmin = FX_MIN;
        p = (wa * wb + (128'sd1 <<< 27)) >>> 28;
        if (p > wmax) return FX_MAX;
        if (p < wmin) return FX_MIN;
        return p[63:0];
    endfunction

    function automatic fx_t fx_div(fx_t n, fx_t d);
        logic [63:0]  mn, md;
        logic [127:0] un, ud, q;
        fx_t r;
        mn = n[63] ? ~n + 64'd1 : n;
        md = d[63] ? ~d + 64'd1 : d;
        un = {64'd0, mn} << 28;
        ud = {64'd0, md};
        q = un / ud;
        if (q > 128'h7fffffffffffffff) q = 128'h7fffffffffffffff;
        r = q[63:0];
        return (n[63] != d[63]) ? -r : r;
    endfunction

    function automatic void lens_terms(fx_t x, fx_t y, output fx_t x2, output fx_t y2,
                                       output fx_t xy, output fx_t r2, output fx_t r4,
                                       output fx_t rad);
        fx_t r6;
        x2 = fx_mul(x, x);
        y2 = fx_mul(y, y);
        xy = fx_mul(x, y);
        r2 = sat_add(x2, y2);
        r4 = fx_mul(r2, r2);
        r6 = fx_mul(r4, r2);
        rad = sat_add(sat_add(fx_mul(c_k1, r2), fx_mul(c_k2, r4)), fx_mul(c_k3, r6));
    endfunction

    function automatic void distort_point(fx_t x, fx_t y, output fx_t xd, output fx_t yd);
        fx_t x2, y2, xy, r2, r4, rad, dx, dy;
        lens_terms(x, y, x2, y2, xy, r2, r4, rad);
        dx = sat_add(sat_add(fx_mul(x, rad), rep_add(fx_mul(c_p1, xy), 2)),
                     fx_mul(c_p2, sat_add(r2, rep_add(x2, 2))));
        dy = sat_add(sat_add(fx_mul(y, rad), rep_add(fx_mul(c_p2, xy), 2)),
                     fx_mul(c_p1, sat_add(r2, rep_add(y2, 2))));
        xd = sat_add(x, dx);
        yd = sat_add(y, dy);
    endfunction

    function automatic void lens_jacobian(fx_t x, fx_t y, output fx_t ja, output fx_t jb,
                                          output fx_t jd);
        fx_t x2, y2, xy, r2, r4, rad, g, base;
        lens_terms(x, y, x2, y2, xy, r2, r4, rad);
        g = sat_add(sat_add(rep_add(c_k1, 2), rep_add(fx_mul(c_k2, r2), 4)),
                    rep_add(fx_mul(c_k3, r4), 6));
        base = sat_add(ONE_FX, rad);
        ja = sat_add(sat_add(sat_add(base, fx_mul(g, x2)), rep_add(fx_mul(c_p1, y), 2)),
                     rep_add(fx_mul(c_p2, x), 6));
        jb = sat_add(sat_add(fx_mul(g, xy), rep_add(fx_mul(c_p1, x), 2)),
                     rep_add(fx_mul(c_p2, y), 2));
        jd = sat_add(sat_add(sat_add(base, fx_mul(g, y2)), rep_add(fx_mul(c_p2, x), 2)),
                     rep_add(fx_mul(c_p1, y), 6));
    endfunction

    function automatic logic [31:0] clamp32(fx_t v);
        if (v > 64'sh7fffffff) return 32'h7fffffff;
        if (v < -64'sh80000000) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic point_res_t predict_point(logic mode, logic [31:0] xi, logic [31:0] yi);
        fx_t x, y, rx, ry, xd, yd, ja, jb, jd, ex, ey, det;
        point_res_t r;
        x = $signed(xi);
        y = $signed(yi);
        rx = x;
        ry = y;
        r.sing = 0;
        if (mode == MODE_DIST) begin
            distort_point(x, y, rx, ry);
        end else if (sat_add(fx_mul(x, x), fx_mul(y, y)) >= NEAR_EPS) begin
            for (int i = 0; i < c_steps; i++) begin
                distort_point(rx, ry, xd, yd);
                lens_jacobian(rx, ry, ja, jb, jd);
                ex = sat_sub(x, xd);
                ey = sat_sub(y, yd);
                det = sat_sub(fx_mul(ja, jd), fx_mul(jb, jb));
                if (det == 0) begin
                    r.sing = 1;
                    break;
                end
                rx = sat_add(rx, fx_div(sat_sub(fx_mul(jd, ex), fx_mul(jb, ey)), det));
                ry = sat_add(ry, fx_div(sat_sub(fx_mul(ja, ey), fx_mul(jb, ex)), det));
            end
        end
        r.x = clamp32(rx);
        r.y = clamp32(ry);
        return r;
    endfunction

    // hold until every result is back, then write all six registers
    task automatic load_coeffs(coeffs_t c);
        logic [31:0] vals[6];
        logic [rdu_pkg::CFG_IDX_W-1:0] idx[6];
        vals = '{c.k1, c.k2, c.k3, c.p1, c.p2, {24'd0, c.steps}};
        idx = '{rdu_pkg::REG_K1, rdu_pkg::REG_K2, rdu_pkg::REG_K3, rdu_pkg::REG_P1,
                rdu_pkg::REG_P2, rdu_pkg::REG_STEPS};
        s_valid <= 0;
        do @(posedge aclk); while (pending_points.size() != 0);
        repeat (4) @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            cfg_we <= 1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 0;
        c_k1 = $signed(c.k1);
        c_k2 = $signed(c.k2);
        c_k3 = $signed(c.k3);
        c_p1 = $signed(c.p1);
        c_p2 = $signed(c.p2);
        c_steps = c.steps;
    endtask

    task automatic offer_point(logic mode, logic [31:0] x, logic [31:0] y, logic lit,
                               point_res_t lit_res);
        while (!calm && $urandom_range(99) < 23) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_mode <= mode;
        s_x_in <= x;
        s_y_in <= y;
        do @(posedge aclk); while (!s_ready);
        pending_points.push_back(lit ? lit_res : predict_point(mode, x, y));
        requests_sent++;
    endtask

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'h7fffffff;
            3: return 32'h80000000;
            default: return $urandom_range(32'h02000000) - 32'h01000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2) return $urandom;
        if (pick == 2) return $urandom_range(400) - 200;
        return $urandom_range(32'h30000000) - 32'h18000000;
    endfunction

    stim_row_t  rows[$];
    coeffs_t    csets[6];

    initial begin
        int cur;
        coeffs_t rc;
        point_res_t lr;
        csets[0] = '{k1: 0, k2: 0, k3: 0, p1: 0, p2: 0, steps: 8'd200};
        csets[1] = '{k1: 0, k2: 0, k3: 0, p1: 0, p2: 0, steps: 8'd0};
        csets[2] = '{k1: 32'hf0000000, k2: 0, k3: 0, p1: 0, p2: 0, steps: 8'd4};
        csets[3] = '{k1: 32'h7fffffff, k2: 32'h7fffffff, k3: 32'h7fffffff,
                     p1: 32'h7fffffff, p2: 32'h7fffffff, steps: 8'd1};
        csets[4] = '{k1: 32'h80000000, k2: 32'h80000000, k3: 32'h80000000,
                     p1: 32'h80000000, p2: 32'h80000000, steps: 8'd255};
        csets[5] = '{k1: -32'sd75161928, k2: 32'd18790482, k3: 32'd268435,
                     p1: 32'd53687, p2: -32'sd80530, steps: 8'd8};

        // reset values: zero coefficients leave the point as it is
        rows.push_back('{cset: 0, mode: MODE_DIST, x: 0, y: 0, lit: 1, ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 0, mode: MODE_DIST, x: 32'h7fffffff, y: 32'h80000000, lit: 1,
                         ex: 32'h7fffffff, ey: 32'h80000000, es: 0});
        // near center passes through
        rows.push_back('{cset: 0, mode: MODE_UNDIST, x: 1, y: 32'hffffffff, lit: 1,
                         ex: 1, ey: 32'hffffffff, es: 0});
        rows.push_back('{cset: 0, mode: MODE_UNDIST, x: 32'h08000000, y: 32'h04000000,
                         lit: 0, ex: 0, ey: 0, es: 0});
        // zero steps return the input
        rows.push_back('{cset: 1, mode: MODE_UNDIST, x: 32'h12345678, y: 32'hedcba987, lit: 1,
                         ex: 32'h12345678, ey: 32'hedcba987, es: 0});
        // k1 = -1 makes the Jacobian singular at (1, 0)
        rows.push_back('{cset: 2, mode: MODE_UNDIST, x: 32'h10000000, y: 0, lit: 1,
                         ex: 32'h10000000, ey: 0, es: 1});
        rows.push_back('{cset: 2, mode: MODE_DIST, x: 32'h10000000, y: 0, lit: 0,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 3, mode: MODE_DIST, x: 32'h7fffffff, y: 32'h7fffffff, lit: 0,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 3, mode: MODE_DIST, x: 32'h80000000, y: 32'h7fffffff, lit: 0,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 3, mode: MODE_UNDIST, x: 32'h80000000, y: 32'h80000000, lit: 0,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 4, mode: MODE_DIST, x: 32'h80000000, y: 32'h80000000, lit: 0,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 4, mode: MODE_UNDIST, x: 32'h04000000, y: 32'hfc000000,
                         lit: 0, ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 4, mode: MODE_UNDIST, x: 0, y: 0, lit: 1,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 5, mode: MODE_DIST, x: 32'h06000000, y: 32'hfd000000, lit: 0,
                         ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 5, mode: MODE_UNDIST, x: 32'h06000000, y: 32'hfd000000,
                         lit: 0, ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 5, mode: MODE_UNDIST, x: 32'hf0000000, y: 32'h0c000000,
                         lit: 0, ex: 0, ey: 0, es: 0});
        rows.push_back('{cset: 5, mode: MODE_DIST, x: 32'h7fffffff, y: 32'h80000000, lit: 0,
                         ex: 0, ey: 0, es: 0});

        repeat (2) @(posedge aclk);
        aresetn <= 1;
        // writes to indexes past the list must change nothing
        cfg_we <= 1;
        cfg_index <= REG_UNUSED_A;
        cfg_wdata <= 32'hdeadbeef;
        @(posedge aclk);
        cfg_index <= REG_UNUSED_B;
        cfg_wdata <= 32'h55aa55aa;
        @(posedge aclk);
        cfg_we <= 0;

        cur = 0;
        foreach (rows[i]) begin
            if (rows[i].cset != cur) begin
                cur = rows[i].cset;
                load_coeffs(csets[cur]);
            end
            lr = '{x: rows[i].ex, y: rows[i].ey, sing: rows[i].es};
            offer_point(rows[i].mode, rows[i].x, rows[i].y, rows[i].lit, lr);
        end

        for (int i = 0; i < 135; i++) begin
            if (i % 25 == 0) begin
                rc = '{k1: rand_coeff(), k2: rand_coeff(), k3: rand_coeff(),
                       p1: rand_coeff(), p2: rand_coeff(),
                       steps: ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 4))};
                load_coeffs(rc);
            end
            calm = (i >= 60 && i < 100);
            offer_point(logic'($urandom_range(1)), rand_coord(), rand_coord(), 0, lr);
        end
        calm = 0;
        s_valid <= 0;
        do @(posedge aclk); while (pending_points.size() != 0);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // result side: check, then decide ready for the next cycle
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge aclk) begin
        point_res_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h %b",
                                               m_x_out, m_y_out, m_singular);
            end else begin
                e = pending_points.pop_front();
                if (m_x_out !== e.x || m_y_out !== e.y || m_singular !== e.sing) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %b, got %h %h %b",
                                 e.x, e.y, e.sing, m_x_out, m_y_out, m_singular);
                end
            end
        end
        if (!hold_done && requests_sent >= 40) begin
            hold_done = 1;
            hold_left = 20000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else if (calm) begin
            m_ready <= 1;
        end else begin
            m_ready <= ($urandom_range(99) >= 23);
        end
    end

    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

/* radtan_distort_undistort_core.f */
src/rdu_pkg.sv
src/rdu_ram.sv
src/rdu_alu.sv
src/radtan_distort_undistort_core.sv
verif/testbench.sv
